// ----- hw/rtl/decimal_lcd_segment_writer_unit_defines.svh -----
// Assertion macros used by the segment writer datapath.
`ifndef DECIMAL_LCD_SEGMENT_WRITER_UNIT_DEFINES_SVH
`define DECIMAL_LCD_SEGMENT_WRITER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DLSW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dlsw: check failed");
`define DLSW_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("dlsw: sequence check failed");
`else
`define DLSW_ASSERT(lbl, prop)
`define DLSW_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ----- hw/rtl/dlsw_pkg.sv -----
// Package: constants, microcode format, program ROM and segment table.
package dlsw_pkg;

  localparam int DIGIT_POSITIONS_DEF = 6;
  localparam int LCD_REGISTERS_DEF   = 20;
  localparam int ROW_STRIDE          = 5;
  localparam int ROWS                = 4;
  localparam logic [3:0]  KEEP_MASK  = 4'b0110;
  // ceil(2^35 / 10): exact quotient by ten for any 32-bit value
  localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;

  typedef logic [1:0] step_t;

  localparam step_t STEP_LOAD  = 2'd0;
  localparam step_t STEP_MUL   = 2'd1;
  localparam step_t STEP_DIGIT = 2'd2;
  localparam step_t STEP_EMIT  = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_MUL,
    OP_DIGIT,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_WAIT_IN,
    COND_LOOP_POS,
    COND_EMIT_DONE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic digit;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic pos_zero;
    logic emit_last;
    logic slot_free;
  } stat_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t uc;
    unique case (step)
      STEP_LOAD:  uc = '{op: OP_LOAD,  cond: COND_WAIT_IN,   target: STEP_MUL};
      STEP_MUL:   uc = '{op: OP_MUL,   cond: COND_NEXT,      target: STEP_DIGIT};
      STEP_DIGIT: uc = '{op: OP_DIGIT, cond: COND_LOOP_POS,  target: STEP_MUL};
      STEP_EMIT:  uc = '{op: OP_EMIT,  cond: COND_EMIT_DONE, target: STEP_LOAD};
      default:    uc = '{op: OP_LOAD,  cond: COND_WAIT_IN,   target: STEP_MUL};
    endcase
    return uc;
  endfunction

  function automatic logic [15:0] seg_pattern(input logic [3:0] d);
    logic [15:0] p;
    unique case (d)
      4'd0:    p = 16'h1551;
      4'd1:    p = 16'h0110;
      4'd2:    p = 16'h1E11;
      4'd3:    p = 16'h1B11;
      4'd4:    p = 16'h0B50;
      4'd5:    p = 16'h1B41;
      4'd6:    p = 16'h1F41;
      4'd7:    p = 16'h0111;
      4'd8:    p = 16'h1F51;
      4'd9:    p = 16'h0B51;
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

endpackage

// ----- hw/rtl/dlsw_sequencer.sv -----
// Microcode sequencer: step counter, program ROM and jump logic.
module dlsw_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  dlsw_pkg::stat_t  stat,
  output logic             in_ready,
  output dlsw_pkg::ctrl_t  ctrl
);

  dlsw_pkg::step_t  step;
  dlsw_pkg::step_t  step_next;
  dlsw_pkg::ucode_t uc;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= dlsw_pkg::STEP_LOAD;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    uc         = dlsw_pkg::ucode_rom(step);
    in_ready   = (uc.op == dlsw_pkg::OP_LOAD);
    ctrl.load  = (uc.op == dlsw_pkg::OP_LOAD) && in_valid;
    ctrl.mul   = (uc.op == dlsw_pkg::OP_MUL);
    ctrl.digit = (uc.op == dlsw_pkg::OP_DIGIT);
    ctrl.emit  = (uc.op == dlsw_pkg::OP_EMIT) && stat.slot_free;
    step_next  = step;
    unique case (uc.cond)
      dlsw_pkg::COND_NEXT: begin
        step_next = step + 2'd1;
      end
      dlsw_pkg::COND_WAIT_IN: begin
        if (in_valid) step_next = step + 2'd1;
      end
      // loop back for the next digit until position zero is done
      dlsw_pkg::COND_LOOP_POS: begin
        step_next = stat.pos_zero ? step + 2'd1 : uc.target;
      end
      dlsw_pkg::COND_EMIT_DONE: begin
        if (stat.slot_free && stat.emit_last) step_next = uc.target;
      end
      default: begin
        step_next = step;
      end
    endcase
  end

endmodule

// ----- hw/rtl/dlsw_datapath.sv -----
// Datapath: divide-by-ten digit unit, LCD register file and output register.
`include "decimal_lcd_segment_writer_unit_defines.svh"

module dlsw_datapath #(
  parameter int DIGIT_POSITIONS = dlsw_pkg::DIGIT_POSITIONS_DEF,
  parameter int LCD_REGISTERS   = dlsw_pkg::LCD_REGISTERS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  dlsw_pkg::ctrl_t     ctrl,
  input  logic signed [31:0]  number,
  output dlsw_pkg::stat_t     stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_data,
  output logic                out_last
);

  localparam int PW = (DIGIT_POSITIONS > 1) ? $clog2(DIGIT_POSITIONS) : 1;
  localparam int AW = $clog2(LCD_REGISTERS);
  localparam logic [PW-1:0] POS_LAST = PW'(DIGIT_POSITIONS - 1);

  logic [30:0]                x;
  logic [27:0]                q;
  logic [62:0]                prod;
  logic [3:0]                 rem;
  logic [3:0]                 digits [DIGIT_POSITIONS];
  logic [DIGIT_POSITIONS-1:0] valid;
  logic [7:0]                 mem [LCD_REGISTERS];
  logic [PW-1:0]              pos;
  logic [1:0]                 row;

  logic        positive;
  logic [15:0] pattern;
  logic [4:0]  off;
  logic        in_range;
  logic [7:0]  cur;
  logic [3:0]  nib;
  logic [7:0]  new_byte;
  logic [7:0]  wr_data;

  assign positive = (number != 32'sd0) && !number[31];
  assign prod     = x * dlsw_pkg::RECIP_TEN;
  assign rem      = 4'(x - {q, 3'b000} - 31'({q, 1'b0}));

  assign pattern  = valid[pos] ? dlsw_pkg::seg_pattern(digits[pos]) : 16'h0000;
  assign off      = 5'(pos >> 1) + 5'(dlsw_pkg::ROW_STRIDE * row);
  assign in_range = {1'b0, off} < 6'(LCD_REGISTERS);
  assign cur      = mem[off[AW-1:0]];

  always_comb begin
    nib = pattern[{row, 2'b00} +: 4];
    // row 0 keeps two bits of the nibble already in the register
    if (row == 2'd0) begin
      nib = nib | ((pos[0] ? cur[7:4] : cur[3:0]) & dlsw_pkg::KEEP_MASK);
    end
    new_byte = pos[0] ? {nib, cur[3:0]} : {cur[7:4], nib};
    wr_data  = in_range ? new_byte : 8'h00;
  end

  assign stat.pos_zero  = (pos == '0);
  assign stat.emit_last = (pos == POS_LAST) && (row == 2'(dlsw_pkg::ROWS - 1));
  assign stat.slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      row       <= '0;
      valid     <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < LCD_REGISTERS; i++) mem[i] <= 8'h00;
    end else begin
      if (ctrl.load) begin
        pos <= POS_LAST;
      end
      if (ctrl.digit) begin
        valid[pos] <= (x != '0);
        if (pos == '0) begin
          row <= '0;
        end else begin
          pos <= pos - 1'b1;
        end
      end
      if (ctrl.emit) begin
        if (in_range) mem[off[AW-1:0]] <= new_byte;
        if (row == 2'(dlsw_pkg::ROWS - 1)) begin
          row <= '0;
          if (!stat.emit_last) pos <= pos + 1'b1;
        end else begin
          row <= row + 2'd1;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x <= positive ? number[30:0] : '0;
    end
    if (ctrl.mul) begin
      q <= 28'(prod >> 35);
    end
    if (ctrl.digit) begin
      digits[pos] <= rem;
      x           <= 31'(q);
    end
    if (ctrl.emit) begin
      out_data <= {3'b000, wr_data, off};
      out_last <= stat.emit_last;
    end
  end

  `DLSW_ASSERT(a_emit_slot, ctrl.emit |-> (!out_valid || out_ready))
  `DLSW_ASSERT_NEXT(a_load_pos, ctrl.load, pos == POS_LAST)
  `DLSW_ASSERT_NEXT(a_digits_done, ctrl.digit && (pos == '0), (pos == '0) && (row == 2'd0))
  `DLSW_ASSERT(a_offset_range, out_valid |-> ({1'b0, out_data[4:0]} < 6'(LCD_REGISTERS)))

endmodule

// ----- hw/rtl/decimal_lcd_segment_writer_unit.sv -----
// Digit extraction runs a multiply step and a digit step per position through one divide-by-ten unit.
// Register writes follow the last digit step, one write per cycle while m_tready holds;
// a new number is taken after the last write.
// Reset (rst, synchronous) returns to the wait step, clears display memory and digit flags,
// and empties the output register.
module decimal_lcd_segment_writer_unit #(
  parameter int DIGIT_POSITIONS = dlsw_pkg::DIGIT_POSITIONS_DEF,
  parameter int LCD_REGISTERS   = dlsw_pkg::LCD_REGISTERS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic signed [31:0] s_tdata,   // [31:0] number
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata,   // [4:0] reg_offset, [12:5] reg_data, [15:13] zero
  output logic               m_tlast    // last_write
);

  dlsw_pkg::ctrl_t ctrl;
  dlsw_pkg::stat_t stat;

  dlsw_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .stat     (stat),
    .in_ready (s_tready),
    .ctrl     (ctrl)
  );

  dlsw_datapath #(
    .DIGIT_POSITIONS (DIGIT_POSITIONS),
    .LCD_REGISTERS   (LCD_REGISTERS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .number    (s_tdata),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
